// ===== hdl/wrrs_pkg.sv =====
package wrrs_pkg;

    // default ring size
    localparam int HISTORY_DEPTH_DEF = 32;

    // field widths
    localparam int TIME_W   = 32;
    localparam int TEMP_W   = 16;
    localparam int CMD_W    = 2;
    localparam int COUNT_W  = 6;
    localparam int SLOPE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int GAP_W    = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'd1;

    // register reset values
    localparam logic [GAP_W-1:0] MIN_GAP_RST = 16'd100;
    localparam logic [CFG_W-1:0] WINDOW_RST  = 32'd60000;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DEGEN = 2'd2;

    // 60000 ms per minute times the 1/64 to 1/256 format change
    localparam int SCALE_W = 18;
    localparam logic [SCALE_W-1:0] SLOPE_SCALE = 18'd240000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_CLEAR,
        S_READ,
        S_ACC,
        S_DEN,
        S_MUL_SQ,
        S_NUM,
        S_CHK,
        S_MUL_PROD,
        S_DIV_LOAD,
        S_DIV,
        S_SAT,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic push;
        logic clear;
        logic acc;
        logic set_count;
        logic set_few;
        logic den_prep;
        logic mul_step;
        logic num;
        logic prod_load;
        logic div_load;
        logic div_step;
        logic set_slope;
        logic set_degen;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic walk_end;
        logic in_window;
        logic few;
        logic den_zero;
        logic cnt_last;
    } t_dp_stat;

endpackage

// ===== hdl/wrrs_ctrl.sv =====
module wrrs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [wrrs_pkg::CMD_W-1:0]    i_command,
    input  wrrs_pkg::t_dp_stat            i_stat,
    output wrrs_pkg::t_dp_cmd             o_cmd,
    output logic                          busy,
    output logic                          o_done
);

    wrrs_pkg::t_state r_state;
    wrrs_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wrrs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wrrs_pkg::S_IDLE: begin
                if (start) begin
                    unique case (i_command)
                        wrrs_pkg::CMD_PUSH:  n_state = wrrs_pkg::S_PUSH;
                        wrrs_pkg::CMD_QUERY: n_state = wrrs_pkg::S_READ;
                        wrrs_pkg::CMD_CLEAR: n_state = wrrs_pkg::S_CLEAR;
                        default:             n_state = wrrs_pkg::S_DONE;
                    endcase
                end
            end
            wrrs_pkg::S_PUSH:  n_state = wrrs_pkg::S_DONE;
            wrrs_pkg::S_CLEAR: n_state = wrrs_pkg::S_DONE;
            wrrs_pkg::S_READ: begin
                n_state = i_stat.walk_end ? wrrs_pkg::S_DEN : wrrs_pkg::S_ACC;
            end
            wrrs_pkg::S_ACC: begin
                n_state = i_stat.in_window ? wrrs_pkg::S_READ : wrrs_pkg::S_DEN;
            end
            wrrs_pkg::S_DEN: begin
                n_state = i_stat.few ? wrrs_pkg::S_DONE : wrrs_pkg::S_MUL_SQ;
            end
            wrrs_pkg::S_MUL_SQ: begin
                if (i_stat.cnt_last) n_state = wrrs_pkg::S_NUM;
            end
            wrrs_pkg::S_NUM: n_state = wrrs_pkg::S_CHK;
            wrrs_pkg::S_CHK: begin
                n_state = i_stat.den_zero ? wrrs_pkg::S_DONE : wrrs_pkg::S_MUL_PROD;
            end
            wrrs_pkg::S_MUL_PROD: begin
                if (i_stat.cnt_last) n_state = wrrs_pkg::S_DIV_LOAD;
            end
            wrrs_pkg::S_DIV_LOAD: n_state = wrrs_pkg::S_DIV;
            wrrs_pkg::S_DIV: begin
                if (i_stat.cnt_last) n_state = wrrs_pkg::S_SAT;
            end
            wrrs_pkg::S_SAT:  n_state = wrrs_pkg::S_DONE;
            wrrs_pkg::S_DONE: n_state = wrrs_pkg::S_IDLE;
            default:          n_state = wrrs_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd  = '0;
        busy   = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            wrrs_pkg::S_IDLE: begin
                busy        = 1'b0;
                o_cmd.latch = start;
            end
            wrrs_pkg::S_PUSH:  o_cmd.push = 1'b1;
            wrrs_pkg::S_CLEAR: o_cmd.clear = 1'b1;
            wrrs_pkg::S_READ:  o_cmd = '0;
            wrrs_pkg::S_ACC:   o_cmd.acc = i_stat.in_window;
            wrrs_pkg::S_DEN: begin
                o_cmd.set_count = 1'b1;
                o_cmd.set_few   = i_stat.few;
                o_cmd.den_prep  = !i_stat.few;
            end
            wrrs_pkg::S_MUL_SQ:   o_cmd.mul_step = 1'b1;
            wrrs_pkg::S_NUM:      o_cmd.num = 1'b1;
            wrrs_pkg::S_CHK: begin
                o_cmd.set_degen = i_stat.den_zero;
                o_cmd.prod_load = !i_stat.den_zero;
            end
            wrrs_pkg::S_MUL_PROD: o_cmd.mul_step = 1'b1;
            wrrs_pkg::S_DIV_LOAD: o_cmd.div_load = 1'b1;
            wrrs_pkg::S_DIV:      o_cmd.div_step = 1'b1;
            wrrs_pkg::S_SAT:      o_cmd.set_slope = 1'b1;
            wrrs_pkg::S_DONE:     o_done = 1'b1;
            default:              o_cmd = '0;
        endcase
    end

endmodule

// ===== hdl/wrrs_dp.sv =====
module wrrs_dp #(
    parameter int HISTORY_DEPTH = wrrs_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wrrs_pkg::t_dp_cmd                    i_cmd,
    output wrrs_pkg::t_dp_stat                   o_stat,
    input  logic [wrrs_pkg::TIME_W-1:0]          i_timestamp_ms,
    input  logic signed [wrrs_pkg::TEMP_W-1:0]   i_temperature,
    input  logic                                 i_cfg_wr_en,
    input  logic [wrrs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wrrs_pkg::CFG_W-1:0]           i_cfg_wdata,
    output logic                                 o_accepted,
    output logic [wrrs_pkg::COUNT_W-1:0]         o_window_count,
    output logic signed [wrrs_pkg::SLOPE_W-1:0]  o_slope,
    output logic [wrrs_pkg::STATUS_W-1:0]        o_status
);

    localparam int TW     = wrrs_pkg::TIME_W;
    localparam int CW     = wrrs_pkg::TEMP_W;
    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int ST_W   = TW + CNT_W;
    localparam int SC_W   = CW + CNT_W;
    localparam int TC_W   = TW + CW;
    localparam int TT_W   = 2 * TW;
    localparam int STC_W  = TC_W + CNT_W;
    localparam int STT_W  = TT_W + CNT_W;
    localparam int DEN_W  = STT_W + CNT_W;
    localparam int NUM_W  = STC_W + CNT_W + 1;
    localparam int PROD_W = NUM_W + wrrs_pkg::SCALE_W;
    localparam int MB_W   = ST_W;
    localparam int STEP_W = $clog2(PROD_W + 1);
    localparam int SW     = wrrs_pkg::SLOPE_W;

    // configuration registers
    logic [wrrs_pkg::GAP_W-1:0] r_min_gap;
    logic [TW-1:0]              r_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap <= wrrs_pkg::MIN_GAP_RST;
            r_window  <= wrrs_pkg::WINDOW_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                wrrs_pkg::CFG_MIN_GAP: r_min_gap <= i_cfg_wdata[wrrs_pkg::GAP_W-1:0];
                wrrs_pkg::CFG_WINDOW:  r_window  <= i_cfg_wdata;
                default:               r_window  <= r_window;
            endcase
        end
    end

    // history control state
    logic [PTR_W-1:0] r_wp;
    logic [CNT_W-1:0] r_fill;
    logic             r_have_prev;
    logic [TW-1:0]    r_last_push;

    // latched item
    logic [TW-1:0]        r_now;
    logic signed [CW-1:0] r_temp;

    // walk state
    logic [PTR_W-1:0]         r_idx;
    logic [CNT_W-1:0]         r_win_n;
    logic signed [ST_W-1:0]   r_st;
    logic signed [SC_W-1:0]   r_sc;
    logic signed [STC_W-1:0]  r_stc;
    logic [STT_W-1:0]         r_stt;

    // fit state
    logic [DEN_W-1:0]         r_nstt;
    logic signed [NUM_W-1:0]  r_nstc;
    logic signed [NUM_W-1:0]  r_stsc;
    logic [DEN_W-1:0]         r_den;
    logic signed [NUM_W-1:0]  r_num;
    logic                     r_neg;

    // shift-add multiplier and restoring divider
    logic [PROD_W-1:0] r_ma;
    logic [MB_W-1:0]   r_mb;
    logic [PROD_W-1:0] r_macc;
    logic [PROD_W-1:0] r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;

    // results
    logic                          r_res_acc;
    logic [wrrs_pkg::COUNT_W-1:0]  r_res_count;
    logic signed [SW-1:0]          r_res_slope;
    logic [wrrs_pkg::STATUS_W-1:0] r_res_status;

    // sample memory
    logic [TW-1:0] mem_time [HISTORY_DEPTH];
    logic [CW-1:0] mem_temp [HISTORY_DEPTH];
    logic [TW-1:0] r_rd_time;
    logic [CW-1:0] r_rd_temp;

    logic [TW-1:0]    gap;
    logic             push_ok;
    logic [PTR_W-1:0] wp_next;
    logic [PTR_W-1:0] newest_idx;
    logic [PTR_W-1:0] idx_prev;

    assign gap        = r_now - r_last_push;
    assign push_ok    = !r_have_prev || (gap >= TW'(r_min_gap));
    assign wp_next    = (r_wp == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign newest_idx = (r_wp == '0) ? PTR_W'(HISTORY_DEPTH - 1) : r_wp - 1'b1;
    assign idx_prev   = (r_idx == '0) ? PTR_W'(HISTORY_DEPTH - 1) : r_idx - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && push_ok) begin
            mem_time[r_wp] <= r_now;
            mem_temp[r_wp] <= r_temp;
        end
        r_rd_time <= mem_time[r_idx];
        r_rd_temp <= mem_temp[r_idx];
    end

    // per-sample terms relative to the newest sample
    logic signed [TW-1:0]    t_rel;
    logic signed [CW-1:0]    c_val;
    logic signed [TC_W-1:0]  tc;
    logic signed [TT_W-1:0]  tt;
    logic [TW-1:0]           age;

    assign age   = r_now - r_rd_time;
    assign t_rel = $signed(r_rd_time - r_last_push);
    assign c_val = $signed(r_rd_temp);
    assign tc    = TC_W'(t_rel) * TC_W'(c_val);
    assign tt    = TT_W'(t_rel) * TT_W'(t_rel);

    // fit terms
    logic [ST_W-1:0]          st_abs;
    logic signed [NUM_W-1:0]  n_sgn;
    logic [DEN_W-1:0]         n_uns;
    logic [PROD_W-1:0]        num_abs;
    logic [DEN_W:0]           rem_sh;
    logic                     rem_ge;
    logic                     q_big;

    assign st_abs  = r_st[ST_W-1] ? ST_W'(-r_st) : ST_W'(r_st);
    assign n_sgn   = NUM_W'($signed({1'b0, r_win_n}));
    assign n_uns   = DEN_W'(r_win_n);
    assign num_abs = r_num[NUM_W-1] ? PROD_W'(-r_num) : PROD_W'(r_num);
    assign rem_sh  = {r_rem, r_quo[PROD_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_den};
    assign q_big   = |r_quo[PROD_W-1:SW-1];

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_fill      <= '0;
            r_have_prev <= 1'b0;
            r_last_push <= '0;
        end else begin
            if (i_cmd.push && push_ok) begin
                r_wp        <= wp_next;
                r_last_push <= r_now;
                r_have_prev <= 1'b1;
                if (r_fill != CNT_W'(HISTORY_DEPTH)) r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.clear) begin
                r_wp        <= '0;
                r_fill      <= '0;
                r_have_prev <= 1'b0;
                r_last_push <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // transfer accepted: latch item, reset walk and results
        if (i_cmd.latch) begin
            r_now        <= i_timestamp_ms;
            r_temp       <= i_temperature;
            r_idx        <= newest_idx;
            r_win_n      <= '0;
            r_st         <= '0;
            r_sc         <= '0;
            r_stc        <= '0;
            r_stt        <= '0;
            r_res_acc    <= 1'b0;
            r_res_count  <= '0;
            r_res_slope  <= '0;
            r_res_status <= wrrs_pkg::ST_OK;
        end
        if (i_cmd.push) r_res_acc <= push_ok;

        // accumulate one in-window sample
        if (i_cmd.acc) begin
            r_idx   <= idx_prev;
            r_win_n <= r_win_n + 1'b1;
            r_st    <= r_st + ST_W'(t_rel);
            r_sc    <= r_sc + SC_W'(c_val);
            r_stc   <= r_stc + STC_W'(tc);
            r_stt   <= r_stt + STT_W'($unsigned(tt));
        end

        if (i_cmd.set_count) r_res_count <= wrrs_pkg::COUNT_W'(r_win_n);
        if (i_cmd.set_few)   r_res_status <= wrrs_pkg::ST_FEW;
        if (i_cmd.set_degen) r_res_status <= wrrs_pkg::ST_DEGEN;

        // products with the count, start squaring the time sum
        if (i_cmd.den_prep) begin
            r_nstt <= n_uns * DEN_W'(r_stt);
            r_nstc <= n_sgn * NUM_W'(r_stc);
            r_stsc <= NUM_W'(r_st) * NUM_W'(r_sc);
            r_ma   <= PROD_W'(st_abs);
            r_mb   <= st_abs;
            r_macc <= '0;
            r_step <= STEP_W'(ST_W);
        end

        // one multiplier bit per cycle
        if (i_cmd.mul_step) begin
            if (r_mb[0]) r_macc <= r_macc + r_ma;
            r_ma   <= r_ma << 1;
            r_mb   <= r_mb >> 1;
            r_step <= r_step - 1'b1;
        end

        if (i_cmd.num) begin
            r_den <= r_nstt - r_macc[DEN_W-1:0];
            r_num <= r_nstc - r_stsc;
        end

        if (i_cmd.prod_load) begin
            r_neg  <= r_num[NUM_W-1];
            r_ma   <= num_abs;
            r_mb   <= MB_W'(wrrs_pkg::SLOPE_SCALE);
            r_macc <= '0;
            r_step <= STEP_W'(wrrs_pkg::SCALE_W);
        end

        if (i_cmd.div_load) begin
            r_quo  <= r_macc;
            r_rem  <= '0;
            r_step <= STEP_W'(PROD_W);
        end

        // one quotient bit per cycle
        if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
            r_quo  <= {r_quo[PROD_W-2:0], rem_ge};
            r_step <= r_step - 1'b1;
        end

        // sign and saturation
        if (i_cmd.set_slope) begin
            if (r_neg) begin
                r_res_slope <= q_big ? {1'b1, {(SW-1){1'b0}}} : -$signed(r_quo[SW-1:0]);
            end else begin
                r_res_slope <= q_big ? {1'b0, {(SW-1){1'b1}}} : $signed(r_quo[SW-1:0]);
            end
        end
    end

    // status to controller
    assign o_stat.walk_end  = (r_win_n == r_fill);
    assign o_stat.in_window = (age <= r_window);
    assign o_stat.few       = (r_win_n < CNT_W'(3));
    assign o_stat.den_zero  = (r_den == '0);
    assign o_stat.cnt_last  = (r_step == STEP_W'(1));

    assign o_accepted     = r_res_acc;
    assign o_window_count = r_res_count;
    assign o_slope        = r_res_slope;
    assign o_status       = r_res_status;

endmodule

// ===== hdl/windowed_rate_of_rise_slope.sv =====
// channel   direction  ports                                         transfer
// command   in         i_command i_timestamp_ms i_temperature        start && !busy
// result    out        o_accepted o_window_count o_slope o_status    o_done
// config    in         i_cfg_index i_cfg_wdata                       i_cfg_wr_en
//
// push and clear: o_done in DONE after the PUSH or CLEAR state; an unused code goes straight to DONE
// query walk: READ and ACC per in-window sample, ending when the ring runs out or at an
// out-of-window sample; then squaring, scaling and divider steps plus control states
// (shift-add multiplier, restoring divider)
// synchronous active-low reset clears history pointers and config registers to defaults
// busy stays high until the result cycle ends; results cannot be held off
module windowed_rate_of_rise_slope #(
    parameter int HISTORY_DEPTH = wrrs_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [wrrs_pkg::CMD_W-1:0]           i_command,
    input  logic [wrrs_pkg::TIME_W-1:0]          i_timestamp_ms,
    input  logic signed [wrrs_pkg::TEMP_W-1:0]   i_temperature,
    input  logic                                 i_cfg_wr_en,
    input  logic [wrrs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wrrs_pkg::CFG_W-1:0]           i_cfg_wdata,
    output logic                                 o_done,
    output logic                                 o_accepted,
    output logic [wrrs_pkg::COUNT_W-1:0]         o_window_count,
    output logic signed [wrrs_pkg::SLOPE_W-1:0]  o_slope,
    output logic [wrrs_pkg::STATUS_W-1:0]        o_status
);

    wrrs_pkg::t_dp_cmd  dp_cmd;
    wrrs_pkg::t_dp_stat dp_stat;

    // sequencer
    wrrs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd),
        .busy      (busy),
        .o_done    (o_done)
    );

    // history, accumulators and arithmetic
    wrrs_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_timestamp_ms (i_timestamp_ms),
        .i_temperature  (i_temperature),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_accepted     (o_accepted),
        .o_window_count (o_window_count),
        .o_slope        (o_slope),
        .o_status       (o_status)
    );

endmodule
